@@ hw/rtl/msv_pkg.sv @@
// msv_pkg: shared types and constants for the masked volume statistics core.
// Holds the volume word that travels from the front accumulator to the back unit.
// No dependencies.
package msv_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int FRAC_BITS     = 8;
   localparam int COUNT_BITS    = 25;
   localparam int SUM_BITS      = 40;
   localparam int SQSUM_BITS    = 56;
   localparam int OUT_BITS      = 24;

   localparam logic [COUNT_BITS-1:0]  MAX_VOXELS = 25'd16777216;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP    = 16'sh7FFF;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOTTOM = 16'sh8000;

   typedef struct packed {
      logic signed [SUM_BITS-1:0]    sum;
      logic [SQSUM_BITS-1:0]         sq_sum;
      logic [COUNT_BITS-1:0]         count;
      logic signed [SAMPLE_BITS-1:0] min_val;
      logic signed [SAMPLE_BITS-1:0] max_val;
      logic                          overflow;
   } msv_rec_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MEAN   = 7'b0000010,
      ST_MUL_A  = 7'b0000100,
      ST_MUL_B  = 7'b0001000,
      ST_VAR    = 7'b0010000,
      ST_ROOT   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } msv_state_type;

endpackage

@@ hw/rtl/masked_volume_statistics_core.sv @@
// masked_volume_statistics_core: top level; front accumulator, word queue, back math.
// Depends on msv_pkg, msv_front, msv_queue, msv_back.
//
// Takes one voxel word per cycle on req_ while the two-entry queue has room. Masked-in
// samples are accumulated; the word flagged last closes the volume and its totals go to
// the back unit, which emits one rsp_ word per volume with mean, sample standard
// deviation (both with 8 fraction bits, truncated), min, max, count and overflow flag.
// For a volume with two or more counted voxels the back unit runs, one step per cycle,
// a 48-step mean divide, 25- and 40-step shift-add products for n*S2 - S^2, a 97-step
// variance divide and a 32-step square root, between the pop and the finish state.
// A single counted voxel goes through pop, mean divide and finish; an empty volume goes
// from the pop straight to finish. When volumes arrive faster than the back unit ends
// them, the queue fills and req_stall rises until the back unit pops a word.
module masked_volume_statistics_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [msv_pkg::SAMPLE_BITS-1:0] req_sample_value,
   input  logic                                  req_in_mask,
   input  logic                                  req_last_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_stats_valid,
   output logic signed [msv_pkg::OUT_BITS-1:0]   rsp_mean_value,
   output logic [msv_pkg::OUT_BITS-1:0]          rsp_std_dev,
   output logic signed [msv_pkg::SAMPLE_BITS-1:0] rsp_min_value,
   output logic signed [msv_pkg::SAMPLE_BITS-1:0] rsp_max_value,
   output logic [msv_pkg::COUNT_BITS-1:0]        rsp_voxel_count,
   output logic                                  rsp_count_overflow
);

   logic                 q_full, q_empty, q_push, q_pop;
   msv_pkg::msv_rec_type q_rec, q_head;

   msv_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_value (req_sample_value),
      .req_in_mask      (req_in_mask),
      .req_last_sample  (req_last_sample),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_rec            (q_rec)
   );

   msv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_rec),
      .pop      (q_pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   msv_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_stats_valid    (rsp_stats_valid),
      .rsp_mean_value     (rsp_mean_value),
      .rsp_std_dev        (rsp_std_dev),
      .rsp_min_value      (rsp_min_value),
      .rsp_max_value      (rsp_max_value),
      .rsp_voxel_count    (rsp_voxel_count),
      .rsp_count_overflow (rsp_count_overflow)
   );

endmodule

@@ hw/rtl/msv_front.sv @@
// msv_front: accepts voxel words, accumulates count, sums, min and max.
// Pushes one msv_pkg::msv_rec_type per volume into the queue. Uses msv_pkg.
module msv_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [msv_pkg::SAMPLE_BITS-1:0] req_sample_value,
   input  logic                                  req_in_mask,
   input  logic                                  req_last_sample,
   input  logic                                  q_full,
   output logic                                  q_push,
   output msv_pkg::msv_rec_type                  q_rec
);

   msv_pkg::msv_rec_type acc_ff, acc_in, nxt;
   logic                 take;
   logic signed [31:0]   prod;

   assign req_stall = q_full;
   assign take      = req_valid && !req_stall;
   assign prod      = req_sample_value * req_sample_value;

   always_comb begin
      nxt = acc_ff;
      if (req_in_mask) begin
         if (acc_ff.count >= msv_pkg::MAX_VOXELS) begin
            nxt.overflow = 1'b1;
         end else begin
            nxt.sum    = acc_ff.sum + msv_pkg::SUM_BITS'(req_sample_value);
            nxt.sq_sum = acc_ff.sq_sum + {24'd0, prod[31:0]};
            nxt.count  = acc_ff.count + 25'd1;
            if (req_sample_value < acc_ff.min_val) nxt.min_val = req_sample_value;
            if (req_sample_value > acc_ff.max_val) nxt.max_val = req_sample_value;
         end
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (take) begin
         if (req_last_sample) begin
            acc_in.sum      = '0;
            acc_in.sq_sum   = '0;
            acc_in.count    = '0;
            acc_in.min_val  = msv_pkg::SAMPLE_TOP;
            acc_in.max_val  = msv_pkg::SAMPLE_BOTTOM;
            acc_in.overflow = 1'b0;
         end else begin
            acc_in = nxt;
         end
      end
   end

   assign q_push = take && req_last_sample;
   assign q_rec  = nxt;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff.sum      <= '0;
         acc_ff.sq_sum   <= '0;
         acc_ff.count    <= '0;
         acc_ff.min_val  <= msv_pkg::SAMPLE_TOP;
         acc_ff.max_val  <= msv_pkg::SAMPLE_BOTTOM;
         acc_ff.overflow <= 1'b0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

@@ hw/rtl/msv_queue.sv @@
// msv_queue: two-entry queue of volume words between front and back.
// Uses msv_pkg.
module msv_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  msv_pkg::msv_rec_type push_rec,
   input  logic                 pop,
   output msv_pkg::msv_rec_type head,
   output logic                 full,
   output logic                 empty
);

   msv_pkg::msv_rec_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop && !full) |=> !empty)
      else $error("queue lost a word");

endmodule

@@ hw/rtl/msv_back.sv @@
// msv_back: per-volume math: mean divide, shift-add products, variance divide,
// integer square root, and the result register. Uses msv_pkg.
module msv_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_empty,
   input  msv_pkg::msv_rec_type                  q_head,
   output logic                                  q_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_stats_valid,
   output logic signed [msv_pkg::OUT_BITS-1:0]   rsp_mean_value,
   output logic [msv_pkg::OUT_BITS-1:0]          rsp_std_dev,
   output logic signed [msv_pkg::SAMPLE_BITS-1:0] rsp_min_value,
   output logic signed [msv_pkg::SAMPLE_BITS-1:0] rsp_max_value,
   output logic [msv_pkg::COUNT_BITS-1:0]        rsp_voxel_count,
   output logic                                  rsp_count_overflow
);

   msv_pkg::msv_state_type state_ff, state_in;
   logic [6:0]   step_ff, step_in;
   logic [39:0]  smag_ff, smag_in, head_smag;
   logic         neg_ff, neg_in;
   msv_pkg::msv_rec_type rec_ff, rec_in;
   logic [96:0]  dvd_ff, dvd_in;
   logic [47:0]  dvs_ff, dvs_in;
   logic [48:0]  rem_ff, rem_in, rem_sh;
   logic [63:0]  quo_ff, quo_in, quo_step;
   logic [80:0]  acc_ff, acc_in, mcand_ff, mcand_in;
   logic [39:0]  mplier_ff, mplier_in;
   logic [63:0]  rx_ff, rx_in, rres_ff, rres_in, rbit_ff, rbit_in, rtry;
   logic [23:0]  mean_ff, mean_in, sd_ff, sd_in;
   logic [49:0]  nn1;
   logic         div_ge, last_step, out_free;
   logic         rv_ff, rv_in;
   logic         o_stats_ff, o_stats_in, o_ovf_ff, o_ovf_in;
   logic [23:0]  o_mean_ff, o_mean_in, o_sd_ff, o_sd_in;
   logic [15:0]  o_min_ff, o_min_in, o_max_ff, o_max_in;
   logic [24:0]  o_cnt_ff, o_cnt_in;

   assign head_smag = q_head.sum[39] ? 40'(-q_head.sum) : 40'(q_head.sum);
   assign rem_sh    = {rem_ff[47:0], dvd_ff[96]};
   assign div_ge    = rem_sh >= {1'b0, dvs_ff};
   assign quo_step  = {quo_ff[62:0], div_ge};
   assign last_step = (step_ff == 7'd0);
   assign nn1       = {25'd0, rec_ff.count} * {25'd0, rec_ff.count - 25'd1};
   assign rtry      = rres_ff + rbit_ff;
   assign out_free  = !rv_ff || !rsp_stall;
   assign q_pop     = (state_ff == msv_pkg::ST_IDLE) && !q_empty;

   always_comb begin
      state_in  = state_ff;
      step_in   = last_step ? 7'd0 : step_ff - 7'd1;
      smag_in   = smag_ff;
      neg_in    = neg_ff;
      rec_in    = rec_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rx_in     = rx_ff;
      rres_in   = rres_ff;
      rbit_in   = rbit_ff;
      mean_in   = mean_ff;
      sd_in     = sd_ff;
      rv_in     = rv_ff && rsp_stall;
      o_stats_in = o_stats_ff;
      o_mean_in  = o_mean_ff;
      o_sd_in    = o_sd_ff;
      o_min_in   = o_min_ff;
      o_max_in   = o_max_ff;
      o_cnt_in   = o_cnt_ff;
      o_ovf_in   = o_ovf_ff;
      unique case (state_ff)
         msv_pkg::ST_IDLE: begin
            if (!q_empty) begin
               rec_in  = q_head;
               smag_in = head_smag;
               neg_in  = q_head.sum[39];
               if (q_head.count == '0) begin
                  mean_in  = '0;
                  sd_in    = '0;
                  state_in = msv_pkg::ST_FINISH;
               end else begin
                  dvd_in   = {head_smag, 8'd0, 49'd0};
                  dvs_in   = {23'd0, q_head.count};
                  rem_in   = '0;
                  quo_in   = '0;
                  step_in  = 7'd47;
                  state_in = msv_pkg::ST_MEAN;
               end
            end
         end
         msv_pkg::ST_MEAN: begin
            rem_in = div_ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
            quo_in = quo_step;
            dvd_in = {dvd_ff[95:0], 1'b0};
            if (last_step) begin
               mean_in = neg_ff ? 24'(~quo_step[23:0] + 24'd1) : quo_step[23:0];
               if (rec_ff.count < 25'd2) begin
                  sd_in    = '0;
                  state_in = msv_pkg::ST_FINISH;
               end else begin
                  dvs_in    = nn1[47:0];
                  acc_in    = '0;
                  mcand_in  = {25'd0, rec_ff.sq_sum};
                  mplier_in = {15'd0, rec_ff.count};
                  step_in   = 7'd24;
                  state_in  = msv_pkg::ST_MUL_A;
               end
            end
         end
         msv_pkg::ST_MUL_A: begin
            if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
            mcand_in  = {mcand_ff[79:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[39:1]};
            if (last_step) begin
               mcand_in  = {41'd0, smag_ff};
               mplier_in = smag_ff;
               step_in   = 7'd39;
               state_in  = msv_pkg::ST_MUL_B;
            end
         end
         msv_pkg::ST_MUL_B: begin
            if (mplier_ff[0]) acc_in = acc_ff - mcand_ff;
            mcand_in  = {mcand_ff[79:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[39:1]};
            if (last_step) begin
               dvd_in   = {acc_in, 16'd0};
               rem_in   = '0;
               quo_in   = '0;
               step_in  = 7'd96;
               state_in = msv_pkg::ST_VAR;
            end
         end
         msv_pkg::ST_VAR: begin
            rem_in = div_ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
            quo_in = quo_step;
            dvd_in = {dvd_ff[95:0], 1'b0};
            if (last_step) begin
               rx_in    = quo_step;
               rres_in  = '0;
               rbit_in  = 64'd1 << 62;
               step_in  = 7'd31;
               state_in = msv_pkg::ST_ROOT;
            end
         end
         msv_pkg::ST_ROOT: begin
            if (rx_ff >= rtry) begin
               rx_in   = rx_ff - rtry;
               rres_in = {1'b0, rres_ff[63:1]} + rbit_ff;
            end else begin
               rres_in = {1'b0, rres_ff[63:1]};
            end
            rbit_in = {2'b00, rbit_ff[63:2]};
            if (last_step) begin
               sd_in    = rres_in[23:0];
               state_in = msv_pkg::ST_FINISH;
            end
         end
         msv_pkg::ST_FINISH: begin
            if (out_free) begin
               rv_in      = 1'b1;
               o_stats_in = (rec_ff.count != '0);
               o_mean_in  = mean_ff;
               o_sd_in    = sd_ff;
               o_min_in   = o_stats_in ? rec_ff.min_val : '0;
               o_max_in   = o_stats_in ? rec_ff.max_val : '0;
               o_cnt_in   = rec_ff.count;
               o_ovf_in   = o_stats_in && rec_ff.overflow;
               state_in   = msv_pkg::ST_IDLE;
            end
         end
         default: state_in = msv_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      smag_ff   <= smag_in;
      neg_ff    <= neg_in;
      rec_ff    <= rec_in;
      dvd_ff    <= dvd_in;
      dvs_ff    <= dvs_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rx_ff     <= rx_in;
      rres_ff   <= rres_in;
      rbit_ff   <= rbit_in;
      mean_ff   <= mean_in;
      sd_ff     <= sd_in;
      o_stats_ff <= o_stats_in;
      o_mean_ff  <= o_mean_in;
      o_sd_ff    <= o_sd_in;
      o_min_ff   <= o_min_in;
      o_max_ff   <= o_max_in;
      o_cnt_ff   <= o_cnt_in;
      o_ovf_ff   <= o_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msv_pkg::ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

   assign rsp_valid          = rv_ff;
   assign rsp_stats_valid    = o_stats_ff;
   assign rsp_mean_value     = o_mean_ff;
   assign rsp_std_dev        = o_sd_ff;
   assign rsp_min_value      = o_min_ff;
   assign rsp_max_value      = o_max_ff;
   assign rsp_voxel_count    = o_cnt_ff;
   assign rsp_count_overflow = o_ovf_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rv_ff && o_sd_ff != '0) |-> (o_cnt_ff > 25'd1))
      else $error("nonzero deviation with fewer than two voxels");
   assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !o_stats_ff) |-> (o_mean_ff == '0 && o_sd_ff == '0 && o_cnt_ff == '0))
      else $error("empty volume result not cleared");
   assert property (@(posedge clock) disable iff (reset)
      (rv_ff && o_stats_ff) |-> ($signed(o_min_ff) <= $signed(o_max_ff)))
      else $error("min above max");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == msv_pkg::ST_FINISH && rv_ff && rsp_stall) |=> rv_ff)
      else $error("pending result overwritten");

endmodule
